// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Op codes, status codes, item structs and datapath widths.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WIDTH = 32;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_EQ  = 4'd4;
  localparam logic [3:0] OP_NE  = 4'd5;
  localparam logic [3:0] OP_LT  = 4'd6;
  localparam logic [3:0] OP_LE  = 4'd7;
  localparam logic [3:0] OP_GT  = 4'd8;
  localparam logic [3:0] OP_GE  = 4'd9;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [3:0]        op;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               cmp_true;
    logic [1:0]         status;
  } out_item_t;

endpackage

// ===== src/rau_if.sv =====
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if: valid/ready channels of the unit
// One item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic              valid;
  logic              ready;
  rau_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rau_out_if;
  logic               valid;
  logic               ready;
  rau_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/rau_mul.sv =====
// ----------------------------------------------------------------------------
// rau_mul: shared 32x32 unsigned multiplier
// Registered product; one product per cycle.
// ----------------------------------------------------------------------------
module rau_mul (
  input  logic        clk,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic [63:0] p
);
  logic [63:0] p_r;
  always_ff @(posedge clk) begin
    p_r <= 64'(x) * 64'(y);
  end
  assign p = p_r;
endmodule

// ===== src/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div: shared 64-bit restoring divider
// One quotient bit a cycle; gives quotient and remainder after 64 steps.
// ----------------------------------------------------------------------------
module rau_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);
  logic [63:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] trial;

  // one shift-subtract step
  always_comb begin
    q_nxt = q_r; r_nxt = r_r; d_nxt = d_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r, q_r[63]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; r_nxt = '0; d_nxt = divisor;
      cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        r_nxt = trial[63:0];
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = {r_r[62:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;
endmodule

// ===== src/rational_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top: signed fraction add/sub/mul/div and compare
// Sequencer around a shared multiplier and a shared serial divider.
// ----------------------------------------------------------------------------
// One item at a time. A comparison passes S_M1, S_M2, S_M3, S_M4, S_FORM and
// S_OUT after its accept; an item rejected for a zero denominator or an unused
// op goes from S_M1 straight to S_OUT. Arithmetic runs the Euclidean gcd on
// the 64-bit magnitudes with the shared one-bit-a-cycle divider, one division
// per remainder step, and then two more divisions for the reduction. Results
// wait in an output register and in_ready stays low until the next item can
// be taken.
module rational_arithmetic_unit_top (
  input  logic      clk,
  input  logic      rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_M1   = 10'b0000000010,
    S_M2   = 10'b0000000100,
    S_M3   = 10'b0000001000,
    S_M4   = 10'b0000010000,
    S_FORM = 10'b0000100000,
    S_GCD  = 10'b0001000000,
    S_DN   = 10'b0010000000,
    S_DD   = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  rau_pkg::in_item_t it_r, it_nxt;
  logic [63:0] p1_r, p1_nxt, p2_r, p2_nxt, pd_r, pd_nxt;
  logic [63:0] nmag_r, nmag_nxt, dmag_r, dmag_nxt, x_r, x_nxt, y_r, y_nxt;
  logic        nneg_r, nneg_nxt;
  rau_pkg::out_item_t res_r, res_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic [31:0] mx, my;
  logic [63:0] mp;
  logic        dstart, ddone;
  logic [63:0] ddvd, ddvs, dq, drem;

  rau_mul u_mul (.clk(clk), .x(mx), .y(my), .p(mp));
  rau_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .dividend(ddvd),
                 .divisor(ddvs), .done(ddone), .quot(dq), .rem(drem));

  // signs and magnitudes of the held operands
  logic an_s, ad_s, bn_s, bd_s;
  logic [31:0] an_m, ad_m, bn_m, bd_m;
  assign an_s = it_r.a_num[31];
  assign ad_s = it_r.a_den[31];
  assign bn_s = it_r.b_num[31];
  assign bd_s = it_r.b_den[31];
  assign an_m = an_s ? 32'(-it_r.a_num) : it_r.a_num;
  assign ad_m = ad_s ? 32'(-it_r.a_den) : it_r.a_den;
  assign bn_m = bn_s ? 32'(-it_r.b_num) : it_r.b_num;
  assign bd_m = bd_s ? 32'(-it_r.b_den) : it_r.b_den;

  logic is_cmp, is_div, is_mul, is_sub;
  assign is_cmp = (it_r.op >= rau_pkg::OP_EQ);
  assign is_div = (it_r.op == rau_pkg::OP_DIV);
  assign is_mul = (it_r.op == rau_pkg::OP_MUL);
  assign is_sub = (it_r.op == rau_pkg::OP_SUB);

  // multiplier operand select by state
  always_comb begin
    mx = an_m; my = bd_m;
    case (state_r)
      S_M1: begin mx = an_m; my = is_mul ? bn_m : bd_m; end
      S_M2: begin mx = is_div ? ad_m : bn_m; my = is_div ? bn_m : ad_m; end
      S_M3: begin mx = ad_m; my = bd_m; end
      default: begin mx = an_m; my = bd_m; end
    endcase
  end

  localparam logic [63:0] LIM = 64'd1 << (rau_pkg::WIDTH - 1);

  logic s1, s2, flip, lt, gt, ch;
  logic [63:0] sum, dif;

  always_comb begin
    state_nxt = state_r; it_nxt = it_r;
    p1_nxt = p1_r; p2_nxt = p2_r; pd_nxt = pd_r;
    nmag_nxt = nmag_r; dmag_nxt = dmag_r; x_nxt = x_r; y_nxt = y_r;
    nneg_nxt = nneg_r; res_nxt = res_r; ovalid_nxt = ovalid_r;
    dstart = 1'b0; ddvd = x_r; ddvs = y_r;
    s1 = 1'b0; s2 = 1'b0; flip = 1'b0; lt = 1'b0; gt = 1'b0; ch = 1'b0;
    sum = p1_r + p2_r; dif = p1_r - p2_r;
    if (out_ch.valid && out_ch.ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_ch.valid) begin
        it_nxt = in_ch.data;
        state_nxt = S_M1;
      end
      S_M1: begin
        res_nxt = '{res_num: '0, res_den: 31'd1, cmp_true: 1'b0,
                    status: rau_pkg::ST_OK};
        if (it_r.op > rau_pkg::OP_GE || it_r.a_den == '0 || it_r.b_den == '0
            || (is_div && it_r.b_num == '0)) begin
          res_nxt.status = rau_pkg::ST_ZERO;
          state_nxt = S_OUT;
        end else state_nxt = S_M2;
      end
      S_M2: begin p1_nxt = mp; state_nxt = S_M3; end
      S_M3: begin p2_nxt = mp; state_nxt = S_M4; end
      S_M4: begin pd_nxt = mp; state_nxt = S_FORM; end
      S_FORM: begin
        flip = ad_s ^ bd_s;
        if (is_cmp) begin
          // signed cross products from magnitudes: lhs = an*bd, rhs = bn*ad
          s1 = (an_s ^ bd_s) && (p1_r != '0);
          s2 = (bn_s ^ ad_s) && (p2_r != '0);
          if (s1 != s2) begin lt = s1; gt = s2; end
          else if (s1) begin lt = p1_r > p2_r; gt = p1_r < p2_r; end
          else begin lt = p1_r < p2_r; gt = p1_r > p2_r; end
          if (flip) begin ch = lt; lt = gt; gt = ch; end
          case (it_r.op)
            rau_pkg::OP_EQ: res_nxt.cmp_true = !lt && !gt;
            rau_pkg::OP_NE: res_nxt.cmp_true = lt || gt;
            rau_pkg::OP_LT: res_nxt.cmp_true = lt;
            rau_pkg::OP_LE: res_nxt.cmp_true = !gt;
            rau_pkg::OP_GT: res_nxt.cmp_true = gt;
            default:        res_nxt.cmp_true = !lt;
          endcase
          state_nxt = S_OUT;
        end else begin
          if (is_mul) begin
            nmag_nxt = p1_r; nneg_nxt = an_s ^ bn_s; dmag_nxt = pd_r;
          end else if (is_div) begin
            nmag_nxt = p1_r; nneg_nxt = (an_s ^ bd_s) ^ (ad_s ^ bn_s);
            dmag_nxt = p2_r; flip = 1'b0;
          end else begin
            s1 = (an_s ^ bd_s) && (p1_r != '0);
            s2 = ((bn_s ^ ad_s) ^ is_sub) && (p2_r != '0);
            if (s1 == s2) begin nmag_nxt = sum; nneg_nxt = s1; end
            else if (p1_r >= p2_r) begin nmag_nxt = dif; nneg_nxt = s1; end
            else begin nmag_nxt = p2_r - p1_r; nneg_nxt = s2; end
            dmag_nxt = pd_r;
          end
          if (flip) nneg_nxt = !nneg_nxt;
          if (nmag_nxt == '0) nneg_nxt = 1'b0;
          x_nxt = nmag_nxt; y_nxt = dmag_nxt;
          state_nxt = S_GCD;
          if (dmag_nxt != '0) begin
            dstart = 1'b1; ddvd = nmag_nxt; ddvs = dmag_nxt;
          end
        end
      end
      // Euclid: x,y <= y, x mod y until y is zero
      S_GCD: if (ddone) begin
        x_nxt = y_r; y_nxt = drem;
        if (drem == '0) begin
          dstart = 1'b1; ddvd = nmag_r; ddvs = y_r;
          state_nxt = S_DN;
        end else begin
          dstart = 1'b1; ddvd = y_r; ddvs = drem;
        end
      end
      S_DN: if (ddone) begin
        nmag_nxt = dq;
        dstart = 1'b1; ddvd = dmag_r; ddvs = x_r;
        state_nxt = S_DD;
      end
      S_DD: if (ddone) begin
        if (dq > LIM - 64'd1 || nmag_r > (nneg_r ? LIM : LIM - 64'd1))
          res_nxt.status = rau_pkg::ST_OVF;
        else begin
          res_nxt.res_num = nneg_r ? 32'(64'd0 - nmag_r) : nmag_r[31:0];
          res_nxt.res_den = dq[30:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: if (!ovalid_r || out_ch.ready) begin
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    it_r <= it_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt; pd_r <= pd_nxt;
    nmag_r <= nmag_nxt; dmag_r <= dmag_nxt; x_r <= x_nxt; y_r <= y_nxt;
    nneg_r <= nneg_nxt;
    if (state_r == S_OUT && (!ovalid_r || out_ch.ready)) out_ch.data <= res_r;
    else if (state_r != S_OUT) res_r <= res_nxt;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
endmodule

// ===== verif/rational_arithmetic_unit_top_test.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top_test: self-checking bench of the fraction unit
// Items are driven on the input channel and checked in order against a
// predictor of add/sub/mul/div with gcd reduction and of the six compares.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int DRAIN_CYCLES   = 8000;

  logic clk;
  logic rst_n;

  rau_in_if  in_ch ();
  rau_out_if out_ch ();

  rational_arithmetic_unit_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rau_pkg::out_item_t expected_results[$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        hold_request   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // magnitude of a signed 64-bit value
  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // expected result of one item
  function automatic rau_pkg::out_item_t predict_result(input rau_pkg::in_item_t it);
    rau_pkg::out_item_t r;
    longint      an, ad, bn, bd, lhs, rhs;
    int          c;
    logic        s1, s2, nneg, dneg, holds;
    logic [63:0] m1, m2, nmag, dmag, x, y, t, lim;
    r.res_num  = '0;
    r.res_den  = 31'd1;
    r.cmp_true = 1'b0;
    r.status   = rau_pkg::ST_OK;
    an = longint'($signed(it.a_num));
    ad = longint'($signed(it.a_den));
    bn = longint'($signed(it.b_num));
    bd = longint'($signed(it.b_den));
    if (it.op > rau_pkg::OP_GE || ad == 0 || bd == 0 ||
        (it.op == rau_pkg::OP_DIV && bn == 0)) begin
      r.status = rau_pkg::ST_ZERO;
      return r;
    end
    // compares: cross products, relation reversed on opposite-sign denominators
    if (it.op >= rau_pkg::OP_EQ) begin
      lhs = an * bd;
      rhs = bn * ad;
      c = (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
      if ((ad < 0) != (bd < 0)) c = -c;
      case (it.op)
        rau_pkg::OP_EQ: holds = (c == 0);
        rau_pkg::OP_NE: holds = (c != 0);
        rau_pkg::OP_LT: holds = (c < 0);
        rau_pkg::OP_LE: holds = (c <= 0);
        rau_pkg::OP_GT: holds = (c > 0);
        default:        holds = (c >= 0);
      endcase
      r.cmp_true = holds;
      return r;
    end
    // arithmetic in sign/magnitude form
    if (it.op == rau_pkg::OP_ADD || it.op == rau_pkg::OP_SUB) begin
      s1 = (an < 0) != (bd < 0);
      s2 = ((bn < 0) != (ad < 0)) != (it.op == rau_pkg::OP_SUB);
      m1 = abs64(an) * abs64(bd);
      m2 = abs64(bn) * abs64(ad);
      if (m1 == 0) s1 = 1'b0;
      if (m2 == 0) s2 = 1'b0;
      if (s1 == s2) begin
        nmag = m1 + m2;
        nneg = s1;
      end else if (m1 >= m2) begin
        nmag = m1 - m2;
        nneg = s1;
      end else begin
        nmag = m2 - m1;
        nneg = s2;
      end
      dmag = abs64(ad) * abs64(bd);
      dneg = (ad < 0) != (bd < 0);
    end else if (it.op == rau_pkg::OP_MUL) begin
      nmag = abs64(an) * abs64(bn);
      nneg = (an < 0) != (bn < 0);
      dmag = abs64(ad) * abs64(bd);
      dneg = (ad < 0) != (bd < 0);
    end else begin
      nmag = abs64(an) * abs64(bd);
      nneg = (an < 0) != (bd < 0);
      dmag = abs64(ad) * abs64(bn);
      dneg = (ad < 0) != (bn < 0);
    end
    if (dneg) nneg = ~nneg;
    if (nmag == 0) nneg = 1'b0;
    // Euclidean gcd and reduction
    x = nmag;
    y = dmag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nmag = nmag / x;
    dmag = dmag / x;
    lim = 64'd1 << (rau_pkg::WIDTH - 1);
    if (dmag > lim - 1 || nmag > (nneg ? lim : lim - 1)) begin
      r.status = rau_pkg::ST_OVF;
      return r;
    end
    r.res_num = nneg ? 32'(64'd0 - nmag) : 32'(nmag);
    r.res_den = 31'(dmag);
    return r;
  endfunction

  // offer one item, with random idle cycles ahead of it
  task automatic send_item(input rau_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_result(it));
  endtask

  function automatic rau_pkg::in_item_t make_item(input logic [3:0] op, input int an,
                                                  input int ad, input int bn,
                                                  input int bd);
    rau_pkg::in_item_t it;
    it.op    = op;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    return it;
  endfunction

  // random operand: full range, small, or an extreme
  function automatic int rand_operand();
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) return int'($urandom());
    if (sel < 8) return $urandom_range(200) - 100;
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic rau_pkg::in_item_t random_item();
    rau_pkg::in_item_t it;
    it.op    = ($urandom_range(99) < 5) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
    it.a_num = rand_operand();
    it.a_den = ($urandom_range(99) < 3) ? 0 : rand_operand();
    it.b_num = ($urandom_range(99) < 3) ? 0 : rand_operand();
    it.b_den = ($urandom_range(99) < 3) ? 0 : rand_operand();
    // equal fractions now and then so compares also hit the equal case
    if ($urandom_range(9) == 0) begin
      it.b_num = it.a_num;
      it.b_den = it.a_den;
    end
    return it;
  endfunction

  task automatic wait_all_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // directed corners: every op, error codes, overflow, sign handling
  task automatic test_directed();
    send_item(make_item(rau_pkg::OP_ADD, 1, 2, 1, 3));
    send_item(make_item(rau_pkg::OP_SUB, 1, 2, 1, 2));
    send_item(make_item(rau_pkg::OP_SUB, 1, 3, 1, 2));
    send_item(make_item(rau_pkg::OP_MUL, 2, -3, 3, 4));
    send_item(make_item(rau_pkg::OP_DIV, -1, 2, 3, -4));
    send_item(make_item(rau_pkg::OP_DIV, 1, 2, 0, 5));
    send_item(make_item(rau_pkg::OP_ADD, 1, 0, 1, 2));
    send_item(make_item(rau_pkg::OP_LT, 1, 2, 1, 0));
    send_item(make_item(4'd10, 1, 1, 1, 1));
    send_item(make_item(4'd15, 1, 1, 1, 1));
    send_item(make_item(rau_pkg::OP_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1));
    send_item(make_item(rau_pkg::OP_MUL, 32'h8000_0000, 1, 1, 1));
    send_item(make_item(rau_pkg::OP_MUL, 32'h8000_0000, -1, 1, 1));
    send_item(make_item(rau_pkg::OP_DIV, 1, 32'h8000_0000, 1, 1));
    send_item(make_item(rau_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff));
    send_item(make_item(rau_pkg::OP_MUL, 0, -7, 5, 3));
    send_item(make_item(rau_pkg::OP_EQ, 1, 2, -2, -4));
    send_item(make_item(rau_pkg::OP_NE, 1, 2, 2, 4));
    send_item(make_item(rau_pkg::OP_LT, 1, -2, 1, 3));
    send_item(make_item(rau_pkg::OP_LE, 1, 2, 1, 2));
    send_item(make_item(rau_pkg::OP_GT, 1, -2, 1, 3));
    send_item(make_item(rau_pkg::OP_GE, 32'h8000_0000, 1, 32'h7fff_ffff, -1));
    send_item(make_item(rau_pkg::OP_LT, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff));
    send_item(make_item(rau_pkg::OP_SUB, 32'h8000_0000, 3, 32'h7fff_ffff, 5));
  endtask

  task automatic test_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_item());
  endtask

  // receiver held off while items keep coming, so the input backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 3000;
    repeat (6) send_item(make_item(4'($urandom_range(9, 4)), rand_operand(), 3,
                                   rand_operand(), -5));
  endtask

  // sender pauses until everything outstanding has come back
  task automatic test_drain_pause();
    in_ch.valid <= 1'b0;
    wait_all_results();
    repeat (5) send_item(random_item());
  endtask

  // result checking and receiver ready
  initial begin
    rau_pkg::out_item_t exp_item;
    int        hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result item: %p", out_ch.data);
        end else begin
          exp_item = expected_results.pop_front();
          if (out_ch.data.res_num !== exp_item.res_num ||
              out_ch.data.res_den !== exp_item.res_den ||
              out_ch.data.cmp_true !== exp_item.cmp_true ||
              out_ch.data.status !== exp_item.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result mismatch: expected %0d/%0d cmp %0b st %0d,",
                        " got %0d/%0d cmp %0b st %0d"},
                       exp_item.res_num, exp_item.res_den, exp_item.cmp_true,
                       exp_item.status, out_ch.data.res_num, out_ch.data.res_den,
                       out_ch.data.cmp_true, out_ch.data.status);
          end
        end
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles without any item moving
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // reset and test sequence
  initial begin
    int waited;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(340, 0, 0);
    test_backpressure();
    test_random(340, 71, 0);
    test_drain_pause();
    test_random(340, 0, 71);
    test_random(340, 24, 24);
    in_ch.valid <= 1'b0;
    wait_all_results();
    waited = 0;
    while (waited < DRAIN_CYCLES && !out_ch.valid) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
